>>> rtl/core/free_range_page_allocator_assert.svh
// assertion macros shared by the allocator checkers
`ifndef FREE_RANGE_PAGE_ALLOCATOR_ASSERT_SVH
`define FREE_RANGE_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FRPA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("frpa check failed");

// next-cycle implication
`define FRPA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("frpa check failed");

`endif

>>> rtl/core/frpa_pkg.sv
// types, constants and helpers of the free page range allocator
`default_nettype none
package frpa_pkg;

	localparam int MAX_RANGES = 64;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_BITS  = 52;
	localparam int PG_W       = ADDR_BITS - PAGE_SHIFT;
	localparam int PC_W       = PG_W + 1;
	localparam int AW         = PG_W + 2;
	localparam int ENT_W      = PG_W + PC_W;
	localparam int PAGE_M1    = (1 << PAGE_SHIFT) - 1;

	typedef logic [AW-1:0] pg_t;

	localparam pg_t TOP_PAGE       = pg_t'(1) << PG_W;
	localparam pg_t TOTAL_MAX      = (pg_t'(1) << PC_W) - pg_t'(1);
	localparam pg_t DMA_LIMIT_PAGE = pg_t'(64'h1_0000_0000 >> PAGE_SHIFT);

	localparam logic [1:0] FN_ADD   = 2'd0;
	localparam logic [1:0] FN_RSV   = 2'd1;
	localparam logic [1:0] FN_ALLOC = 2'd2;
	localparam logic [1:0] FN_FREE  = 2'd3;

	localparam logic [2:0] ST_DONE  = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_NOFIT = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_NRDY  = 3'd4;

	typedef struct packed {
		logic [1:0]           func;
		logic [ADDR_BITS-1:0] base_address;
		logic [ADDR_BITS-1:0] end_address;
		logic [ADDR_BITS-1:0] length_bytes;
		logic [ADDR_BITS-1:0] alignment_bytes;
		logic                 dma32;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [ADDR_BITS-1:0] alloc_base;
		logic [ADDR_BITS:0]   free_bytes;
	} out_item_t;

	typedef struct packed {
		logic [PG_W-1:0] start;
		logic [PC_W-1:0] count;
	} ent_t;

	typedef struct packed {
		pg_t  a;
		pg_t  b;
		logic sub;
	} alu_req_t;

	typedef struct packed {
		pg_t  y;
		logic lt;
	} alu_rsp_t;

	// ones from the highest set bit downward
	function automatic logic [PG_W-1:0] smear(input logic [PG_W-1:0] v);
		logic [PG_W-1:0] r;
		r = v;
		for (int k = 1; k < PG_W; k = k * 2)
			r = r | (r >> k);
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/frpa_ram.sv
// generic single write port ram with registered read
`default_nettype none
module frpa_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] wr_addr,
	input  wire logic [W-1:0]         wr_data,
	input  wire logic                 rd_en,
	input  wire logic [$clog2(D)-1:0] rd_addr,
	output logic      [W-1:0]         rd_data
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> rtl/core/frpa_alu.sv
// shared page adder / subtractor with borrow compare
`default_nettype none
module frpa_alu (
	input  frpa_pkg::alu_req_t req,
	output frpa_pkg::alu_rsp_t rsp
);
	import frpa_pkg::*;

	logic [AW:0] r;
	pg_t         bb;

	always_comb begin
		bb    = req.sub ? ~req.b : req.b;
		r     = {1'b0, req.a} + {1'b0, bb} + {{AW{1'b0}}, req.sub};
		rsp.y  = r[AW-1:0];
		// no carry out on a subtract means a borrow
		rsp.lt = req.sub & ~r[AW];
	end
endmodule
`default_nettype wire

>>> rtl/core/free_range_page_allocator.sv
// free page range allocator: sorted range table walked by a sequencer
// run time grows with the table entries visited and the entries moved
// throughput: one item at a time; the single ram port pair and shared adder set the pace
// reset clears the entry count, free total, ready flag and handshakes; table contents stay
// undefined and need no clearing pass
`default_nettype none
module free_range_page_allocator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  frpa_pkg::in_item_t       in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output frpa_pkg::out_item_t      out_item
);
	import frpa_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0,  S_DEC = 5'd1,  S_INS0 = 5'd2,  S_INS_P = 5'd3;
	localparam logic [4:0] S_INS_PC = 5'd4, S_INS_M = 5'd5, S_INS_MR = 5'd6, S_INS_MA = 5'd7;
	localparam logic [4:0] S_INS_V = 5'd8, S_INS_VR = 5'd9, S_INS_A = 5'd10, S_INS_W = 5'd11;
	localparam logic [4:0] S_INS_T = 5'd12, S_RSV = 5'd13, S_RSV_R = 5'd14, S_RSV_C = 5'd15;
	localparam logic [4:0] S_RSV_C2 = 5'd16, S_RSV_D = 5'd17, S_ALC = 5'd18, S_ALC_R = 5'd19;
	localparam logic [4:0] S_ALC_A = 5'd20, S_ALC_B = 5'd21, S_ALC_C = 5'd22, S_CUT = 5'd23;
	localparam logic [4:0] S_CUT_H = 5'd24, S_CUT_L = 5'd25, S_TOT = 5'd26, S_DROP = 5'd27;
	localparam logic [4:0] S_DROP_W = 5'd28, S_OPEN = 5'd29, S_OPEN_W = 5'd30, S_FIN = 5'd31;

	logic [4:0]       state_q, ret_q;
	in_item_t         in_q;
	out_item_t        out_q;
	logic             out_valid_q, ready_q, got_q;
	logic [2:0]       st_q;
	logic [1:0]       inc_q;
	pg_t              s_q, e_q, c_q, d_q, need_q, amt_q, rs_q, re_q, x_q, y_q;
	logic [PG_W-1:0]  alm_q;
	logic [PC_W-1:0]  total_q;
	logic [CNT_W-1:0] used_q, p_q, i_q, k_q, n_q, at_q;

	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	logic             ram_we, ram_rd_en;
	logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
	ent_t             ram_wr, rd_ent;
	logic [ENT_W-1:0] rd_data;

	frpa_alu u_alu (.req(alu_req), .rsp(alu_rsp));

	frpa_ram #(.W(ENT_W), .D(MAX_RANGES)) u_table (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (rd_data)
	);

	// decode of the item into page terms
	logic [ADDR_BITS:0]   bu, lu;
	logic [ADDR_BITS+1:0] rend;
	pg_t                  s_add, e_add, s_rf, e_rf_raw, e_rf, need_d;
	logic                 add_empty;

	// table walk helpers
	pg_t              rd_rs, rd_cnt;
	logic             full, adj, cut_lo, cut_hi, skip;
	logic [CNT_W:0]   kn;
	logic [CNT_W-1:0] pm1, ip1;
	pg_t              sat;

	always_comb begin
		bu       = {1'b0, in_q.base_address} + (ADDR_BITS+1)'(PAGE_M1);
		lu       = {1'b0, in_q.length_bytes} + (ADDR_BITS+1)'(PAGE_M1);
		rend     = {2'b0, in_q.base_address} + {2'b0, in_q.length_bytes}
		         + (ADDR_BITS+2)'(PAGE_M1);
		s_add    = pg_t'(bu >> PAGE_SHIFT);
		e_add    = pg_t'(in_q.end_address >> PAGE_SHIFT);
		s_rf     = pg_t'(in_q.base_address >> PAGE_SHIFT);
		e_rf_raw = pg_t'(rend >> PAGE_SHIFT);
		e_rf     = (e_rf_raw > TOP_PAGE) ? TOP_PAGE : e_rf_raw;
		need_d   = pg_t'(lu >> PAGE_SHIFT);
		add_empty = (in_q.end_address <= in_q.base_address) || (e_add <= s_add);

		rd_ent = ent_t'(rd_data);
		rd_rs  = pg_t'(rd_ent.start);
		rd_cnt = pg_t'(rd_ent.count);
		full   = (used_q == CNT_W'(MAX_RANGES));
		kn     = {1'b0, k_q} + {1'b0, n_q};
		pm1    = p_q - CNT_W'(1);
		ip1    = i_q + CNT_W'(1);
		adj    = (p_q != '0) && (alu_rsp.y == s_q);
		cut_lo = (x_q == rs_q);
		cut_hi = (y_q == re_q);
		skip   = (in_q.dma32 && (y_q > DMA_LIMIT_PAGE)) || (y_q > re_q);
		sat    = (alu_rsp.y > TOTAL_MAX) ? TOTAL_MAX : alu_rsp.y;
	end

	// shared adder operands and table port control
	always_comb begin
		alu_req     = '0;
		ram_we      = 1'b0;
		ram_wr_addr = '0;
		ram_wr      = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		unique case (state_q)
			S_INS0: alu_req = '{a: e_q, b: s_q, sub: 1'b1};
			S_INS_P: begin
				ram_rd_en   = (p_q < used_q);
				ram_rd_addr = p_q[IDX_W-1:0];
			end
			S_INS_PC: alu_req = '{a: rd_rs, b: s_q, sub: 1'b1};
			S_INS_M: begin
				ram_rd_en   = (i_q < used_q);
				ram_rd_addr = i_q[IDX_W-1:0];
			end
			S_INS_MR: alu_req = '{a: s_q, b: c_q, sub: 1'b0};
			S_INS_MA: alu_req = '{a: c_q, b: rd_cnt, sub: 1'b0};
			S_INS_V: begin
				ram_rd_en   = (p_q != '0);
				ram_rd_addr = pm1[IDX_W-1:0];
			end
			S_INS_VR: begin
				alu_req = '{a: rd_rs, b: rd_cnt, sub: 1'b0};
				if (!adj && i_q > p_q) begin
					ram_we      = 1'b1;
					ram_wr_addr = p_q[IDX_W-1:0];
					ram_wr      = '{start: s_q[PG_W-1:0], count: c_q[PC_W-1:0]};
				end
			end
			S_INS_A: begin
				alu_req     = '{a: rd_cnt, b: c_q, sub: 1'b0};
				ram_we      = 1'b1;
				ram_wr_addr = pm1[IDX_W-1:0];
				ram_wr      = '{start: rd_ent.start, count: alu_rsp.y[PC_W-1:0]};
			end
			S_INS_W: begin
				ram_we      = 1'b1;
				ram_wr_addr = p_q[IDX_W-1:0];
				ram_wr      = '{start: s_q[PG_W-1:0], count: c_q[PC_W-1:0]};
			end
			S_INS_T: alu_req = '{a: pg_t'(total_q), b: d_q, sub: 1'b0};
			S_RSV, S_ALC: begin
				ram_rd_en   = (i_q < used_q);
				ram_rd_addr = i_q[IDX_W-1:0];
			end
			S_RSV_R, S_ALC_R: alu_req = '{a: rd_rs, b: rd_cnt, sub: 1'b0};
			S_RSV_C: alu_req = '{a: s_q, b: re_q, sub: 1'b1};
			S_RSV_C2: alu_req = '{a: rs_q, b: e_q, sub: 1'b1};
			S_RSV_D: alu_req = '{a: y_q, b: x_q, sub: 1'b1};
			S_ALC_A: alu_req = '{a: rs_q, b: pg_t'(alm_q), sub: 1'b0};
			S_ALC_B: alu_req = '{a: x_q, b: need_q, sub: 1'b0};
			S_CUT: begin
				if (cut_lo && !cut_hi) begin
					alu_req     = '{a: re_q, b: y_q, sub: 1'b1};
					ram_we      = 1'b1;
					ram_wr_addr = i_q[IDX_W-1:0];
					ram_wr      = '{start: y_q[PG_W-1:0], count: alu_rsp.y[PC_W-1:0]};
				end else if (!cut_lo && cut_hi) begin
					alu_req     = '{a: x_q, b: rs_q, sub: 1'b1};
					ram_we      = 1'b1;
					ram_wr_addr = i_q[IDX_W-1:0];
					ram_wr      = '{start: rs_q[PG_W-1:0], count: alu_rsp.y[PC_W-1:0]};
				end
			end
			S_CUT_H: begin
				alu_req     = '{a: re_q, b: y_q, sub: 1'b1};
				ram_we      = 1'b1;
				ram_wr_addr = ip1[IDX_W-1:0];
				ram_wr      = '{start: y_q[PG_W-1:0], count: alu_rsp.y[PC_W-1:0]};
			end
			S_CUT_L: begin
				alu_req     = '{a: x_q, b: rs_q, sub: 1'b1};
				ram_we      = 1'b1;
				ram_wr_addr = i_q[IDX_W-1:0];
				ram_wr      = '{start: rs_q[PG_W-1:0], count: alu_rsp.y[PC_W-1:0]};
			end
			S_TOT: alu_req = '{a: pg_t'(total_q), b: amt_q, sub: 1'b1};
			S_DROP: begin
				ram_rd_en   = (kn < {1'b0, used_q});
				ram_rd_addr = kn[IDX_W-1:0];
			end
			S_DROP_W, S_OPEN_W: begin
				ram_we      = 1'b1;
				ram_wr_addr = k_q[IDX_W-1:0];
				ram_wr      = rd_ent;
			end
			S_OPEN: begin
				ram_rd_en   = (k_q > at_q);
				ram_rd_addr = pm1_k(k_q);
			end
			default: ;
		endcase
	end

	function automatic logic [IDX_W-1:0] pm1_k(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] t;
		t = v - CNT_W'(1);
		return t[IDX_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
			ready_q     <= 1'b0;
			used_q      <= '0;
			total_q     <= '0;
			got_q       <= 1'b0;
			st_q        <= ST_DONE;
			inc_q       <= '0;
			p_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			n_q         <= '0;
			at_q        <= '0;
			in_q        <= '0;
			out_q       <= '0;
			s_q         <= '0;
			e_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			need_q      <= '0;
			amt_q       <= '0;
			rs_q        <= '0;
			re_q        <= '0;
			x_q         <= '0;
			y_q         <= '0;
			alm_q       <= '0;
		end else begin
			if (cfg_we)
				ready_q <= cfg_wdata;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q    <= in_item;
						got_q   <= 1'b0;
						st_q    <= ST_DONE;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					i_q    <= '0;
					p_q    <= '0;
					need_q <= need_d;
					amt_q  <= need_d;
					alm_q  <= smear(in_q.alignment_bytes[ADDR_BITS-1:PAGE_SHIFT]) >> 1;
					unique case (in_q.func)
						FN_ADD: begin
							s_q <= s_add;
							e_q <= e_add;
							if (add_empty) begin
								st_q    <= ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_INS0;
							end
						end
						FN_RSV: begin
							s_q <= s_rf;
							e_q <= e_rf;
							if (in_q.length_bytes == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_RSV;
							end
						end
						FN_ALLOC: begin
							if (in_q.length_bytes == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_FIN;
							end else if (!ready_q) begin
								st_q    <= ST_NRDY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_ALC;
							end
						end
						FN_FREE: begin
							s_q <= s_rf;
							e_q <= e_rf;
							if (!ready_q) begin
								st_q    <= ST_NRDY;
								state_q <= S_FIN;
							end else if (in_q.length_bytes == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_INS0;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_INS0: begin
					c_q     <= alu_rsp.y;
					d_q     <= alu_rsp.y;
					state_q <= S_INS_P;
				end
				S_INS_P: begin
					if (p_q < used_q) begin
						state_q <= S_INS_PC;
					end else begin
						i_q     <= p_q;
						state_q <= S_INS_V;
					end
				end
				S_INS_PC: begin
					// first entry at or above the new start
					if (alu_rsp.lt) begin
						p_q     <= p_q + CNT_W'(1);
						state_q <= S_INS_P;
					end else begin
						i_q     <= p_q;
						state_q <= S_INS_M;
					end
				end
				S_INS_M: state_q <= (i_q < used_q) ? S_INS_MR : S_INS_V;
				S_INS_MR: state_q <= (alu_rsp.y == rd_rs) ? S_INS_MA : S_INS_V;
				S_INS_MA: begin
					c_q     <= alu_rsp.y;
					i_q     <= ip1;
					state_q <= S_INS_M;
				end
				S_INS_V: state_q <= S_INS_VR;
				S_INS_VR: begin
					if (adj) begin
						state_q <= S_INS_A;
					end else if (i_q > p_q) begin
						k_q     <= p_q + CNT_W'(1);
						n_q     <= i_q - p_q - CNT_W'(1);
						ret_q   <= S_INS_T;
						state_q <= S_DROP;
					end else if (full) begin
						st_q    <= ST_FULL;
						state_q <= S_FIN;
					end else begin
						at_q    <= p_q;
						k_q     <= used_q;
						ret_q   <= S_INS_W;
						state_q <= S_OPEN;
					end
				end
				S_INS_A: begin
					k_q     <= p_q;
					n_q     <= i_q - p_q;
					ret_q   <= S_INS_T;
					state_q <= S_DROP;
				end
				S_INS_W: state_q <= S_INS_T;
				S_INS_T: begin
					total_q <= sat[PC_W-1:0];
					state_q <= S_FIN;
				end
				S_RSV: state_q <= (i_q < used_q) ? S_RSV_R : S_FIN;
				S_RSV_R: begin
					rs_q    <= rd_rs;
					re_q    <= alu_rsp.y;
					state_q <= S_RSV_C;
				end
				S_RSV_C: begin
					if (!alu_rsp.lt) begin
						i_q     <= ip1;
						state_q <= S_RSV;
					end else begin
						state_q <= S_RSV_C2;
					end
				end
				S_RSV_C2: begin
					x_q <= (s_q > rs_q) ? s_q : rs_q;
					y_q <= (e_q < re_q) ? e_q : re_q;
					state_q <= alu_rsp.lt ? S_RSV_D : S_FIN;
				end
				S_RSV_D: begin
					amt_q   <= alu_rsp.y;
					state_q <= S_CUT;
				end
				S_ALC: begin
					if (i_q < used_q) begin
						state_q <= S_ALC_R;
					end else begin
						st_q    <= ST_NOFIT;
						state_q <= S_FIN;
					end
				end
				S_ALC_R: begin
					rs_q    <= rd_rs;
					re_q    <= alu_rsp.y;
					state_q <= S_ALC_A;
				end
				S_ALC_A: begin
					x_q     <= alu_rsp.y & ~pg_t'(alm_q);
					state_q <= S_ALC_B;
				end
				S_ALC_B: begin
					y_q     <= alu_rsp.y;
					state_q <= S_ALC_C;
				end
				S_ALC_C: begin
					if (skip) begin
						i_q     <= ip1;
						state_q <= S_ALC;
					end else begin
						state_q <= S_CUT;
					end
				end
				S_CUT: begin
					priority if (cut_lo && cut_hi) begin
						inc_q   <= 2'd0;
						k_q     <= i_q;
						n_q     <= CNT_W'(1);
						ret_q   <= S_TOT;
						state_q <= S_DROP;
					end else if (cut_lo || cut_hi) begin
						inc_q   <= 2'd1;
						state_q <= S_TOT;
					end else if (full) begin
						st_q    <= ST_FULL;
						state_q <= S_FIN;
					end else begin
						inc_q   <= 2'd2;
						at_q    <= ip1;
						k_q     <= used_q;
						ret_q   <= S_CUT_H;
						state_q <= S_OPEN;
					end
				end
				S_CUT_H: state_q <= S_CUT_L;
				S_CUT_L: state_q <= S_TOT;
				S_TOT: begin
					total_q <= alu_rsp.lt ? '0 : alu_rsp.y[PC_W-1:0];
					if (in_q.func == FN_ALLOC) begin
						got_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						i_q     <= i_q + CNT_W'(inc_q);
						state_q <= S_RSV;
					end
				end
				S_DROP: begin
					if (kn < {1'b0, used_q}) begin
						state_q <= S_DROP_W;
					end else begin
						used_q  <= used_q - n_q;
						state_q <= ret_q;
					end
				end
				S_DROP_W: begin
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_DROP;
				end
				S_OPEN: begin
					if (k_q > at_q) begin
						state_q <= S_OPEN_W;
					end else begin
						used_q  <= used_q + CNT_W'(1);
						state_q <= ret_q;
					end
				end
				S_OPEN_W: begin
					k_q     <= k_q - CNT_W'(1);
					state_q <= S_OPEN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_q.status     <= st_q;
						out_q.alloc_base <= got_q ? {x_q[PG_W-1:0], {PAGE_SHIFT{1'b0}}} : '0;
						out_q.free_bytes <= {total_q, {PAGE_SHIFT{1'b0}}};
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule
`default_nettype wire

>>> rtl/core/frpa_checker.sv
// port level checks of the allocator and their binding
`default_nettype none
`include "free_range_page_allocator_assert.svh"
module frpa_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input frpa_pkg::in_item_t       in_item,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input frpa_pkg::out_item_t      out_item
);
	import frpa_pkg::*;

	// a stalled result stays put
	`FRPA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	// one item in work at a time
	`FRPA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// status codes stay in range
	`FRPA_ASSERT_NOW(a_status_range, clk, arst_n, out_valid, out_item.status <= ST_NRDY)
	// only a granted allocation returns an address
	`FRPA_ASSERT_NOW(a_base_zero, clk, arst_n, out_valid && out_item.status != ST_DONE, out_item.alloc_base == '0)
endmodule

bind free_range_page_allocator frpa_checker u_frpa_checker (.*);
`default_nettype wire
